### hw/rtl/circ_pkg.sv
package circ_pkg;

    localparam int CW    = 32;
    localparam int DW    = CW + 1;
    localparam int PW    = CW + DW;
    localparam int DETW  = PW + 3;
    localparam int SQW   = 2 * CW;
    localparam int SW    = 2 * CW + 1;
    localparam int PPW   = 2 * DW;
    localparam int SPW   = SW + DW;
    localparam int NW    = SPW + 2;
    localparam int QB    = CW + 1;
    localparam int RW    = (NW > DETW + QB) ? NW : DETW + QB;
    localparam int RB    = CW - 1;
    localparam int RQW   = 2 * DW + 1;
    localparam int RSW   = 2 * RB + 1;
    localparam int TW    = 40;
    localparam logic [TW-1:0] TH_RST = TW'(4295);
    localparam int IN_W  = ((6 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((3 * CW - 1 + 7) / 8) * 8;
    localparam int USR_W = 2;
    localparam int NST   = 8 + QB + 4 + RB + 1;

    typedef struct packed {
        logic                 found;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [RW-1:0]        rem_x;
        logic [RW-1:0]        rem_y;
        logic [QB-1:0]        q_x;
        logic [QB-1:0]        q_y;
        logic                 ovf_x;
        logic                 ovf_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [DETW-1:0]      dmag;
    } t_div;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic          clip;
        logic          sat;
        logic [RSW-1:0] rem;
        logic [RB-1:0] root;
    } t_sqrt;

endpackage

### hw/rtl/circumcircle_of_three_points.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: first_x, first_y, second_x, second_y, third_x, third_y
// m_axis    out  tdata: center_x, center_y, radius; tuser: found, clipped
// cfg       in   wr_data: degenerate_threshold
//
// One triangle is accepted per cycle while m_axis is not stalled; the depth is set by the
// bit-per-stage divider (33 stages) and root extractor (31 stages).
// Synchronous active-low reset clears the valid chain and reloads the threshold.
// A stalled m_axis freezes the whole pipe; s_axis tready follows it.
module circumcircle_of_three_points (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [circ_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // center_x, center_y, radius, zero pad
    output logic [circ_pkg::OUT_W-1:0] o_m_axis_tdata,
    // found, clipped
    output logic [circ_pkg::USR_W-1:0] o_m_axis_tuser,
    input  logic                       i_cfg_wr_en,
    input  logic [circ_pkg::TW-1:0]    i_cfg_wr_data
);
    import circ_pkg::*;

    localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

    logic en, acc;
    logic [NST-1:0] r_vld;
    logic [TW-1:0]  r_thr;

    logic signed [CW-1:0] in_c [6];

    logic signed [CW-1:0] r1_x1, r1_y1, r1_x2, r1_y2, r1_x3, r1_y3;
    logic signed [DW-1:0] r1_d [6];

    logic signed [PW-1:0]  r2_m [3];
    logic signed [SQW-1:0] r2_q [6];
    logic signed [DW-1:0]  r2_d [6];
    logic signed [CW-1:0]  r2_x1, r2_y1;

    logic signed [DETW-1:0] r3_det;
    logic signed [SW-1:0]   r3_s [3];
    logic signed [DW-1:0]   r3_d [6];
    logic signed [CW-1:0]   r3_x1, r3_y1;

    logic signed [PPW-1:0]  r4_lo [6];
    logic signed [PPW-1:0]  r4_hi [6];
    logic signed [DETW-1:0] r4_det;
    logic                   r4_found;
    logic signed [CW-1:0]   r4_x1, r4_y1;
    logic [DETW-1:0]        absdet;

    logic signed [SPW-1:0]  r5_p [6];
    logic signed [DETW-1:0] r5_det;
    logic                   r5_found;
    logic signed [CW-1:0]   r5_x1, r5_y1;

    logic signed [NW-1:0]   r6_nx, r6_ny;
    logic signed [DETW-1:0] r6_det;
    logic                   r6_found;
    logic signed [CW-1:0]   r6_x1, r6_y1;

    logic [NW-1:0]        r7_nmx, r7_nmy;
    logic [DETW-1:0]      r7_dmag;
    logic                 r7_negx, r7_negy, r7_found;
    logic signed [CW-1:0] r7_x1, r7_y1;

    t_div r_dv [QB+1];
    t_div n_dv [QB+1];

    logic [CW-1:0]        n9_cx, n9_cy;
    logic                 n9_clx, n9_cly;
    logic [CW-1:0]        r9_cx, r9_cy;
    logic                 r9_clip, r9_found;
    logic signed [CW-1:0] r9_x1, r9_y1;

    logic signed [DW-1:0] r10_rx, r10_ry;
    logic [CW-1:0]        r10_cx, r10_cy;
    logic                 r10_clip, r10_found;

    logic signed [PPW-1:0] r11_rx2, r11_ry2;
    logic [CW-1:0]         r11_cx, r11_cy;
    logic                  r11_clip, r11_found;
    logic [RQW-1:0]        n12_rsq;

    t_sqrt r_sq [RB+1];
    t_sqrt n_sq [RB+1];

    logic                 r_o_found, r_o_clip;
    logic [CW-1:0]        r_o_cx, r_o_cy;
    logic [RB-1:0]        r_o_rad;

    function automatic logic [CW:0] sat_q(input logic [QB-1:0] q, input logic neg,
                                          input logic ovf);
        logic [QB-1:0] nq;
        nq = QB'(0) - q;
        if (!neg) begin
            if (ovf || q > QB'(MAXP)) sat_q = {1'b1, MAXP};
            else sat_q = {1'b0, q[CW-1:0]};
        end else begin
            if (ovf || q > (QB'(1) << (CW - 1))) sat_q = {1'b1, MINN};
            else sat_q = {1'b0, nq[CW-1:0]};
        end
    endfunction

    assign en  = !r_vld[NST-1] || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    always_comb begin
        for (int i = 0; i < 6; i++) in_c[i] = i_s_axis_tdata[i*CW +: CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= TH_RST;
        end else begin
            if (en) r_vld <= {r_vld[NST-2:0], acc};
            if (i_cfg_wr_en) r_thr <= i_cfg_wr_data;
        end
    end

    assign absdet = r3_det[DETW-1] ? (~r3_det + 1'b1) : r3_det;

    always_comb begin
        logic [RW-1:0] tx, ty;
        n_dv[0] = r_dv[0];
        for (int k = 1; k <= QB; k++) begin
            n_dv[k] = r_dv[k-1];
            tx = RW'(r_dv[k-1].dmag) << (QB - k);
            ty = tx;
            if (r_dv[k-1].rem_x >= tx) begin
                n_dv[k].rem_x = r_dv[k-1].rem_x - tx;
                n_dv[k].q_x[QB-k] = 1'b1;
            end
            if (r_dv[k-1].rem_y >= ty) begin
                n_dv[k].rem_y = r_dv[k-1].rem_y - ty;
                n_dv[k].q_y[QB-k] = 1'b1;
            end
        end
    end

    always_comb begin
        {n9_clx, n9_cx} = sat_q(r_dv[QB].q_x, r_dv[QB].neg_x, r_dv[QB].ovf_x);
        {n9_cly, n9_cy} = sat_q(r_dv[QB].q_y, r_dv[QB].neg_y, r_dv[QB].ovf_y);
    end

    assign n12_rsq = RQW'(r11_rx2) + RQW'(r11_ry2);

    always_comb begin
        logic [RSW-1:0] t;
        n_sq[0] = r_sq[0];
        for (int k = 1; k <= RB; k++) begin
            n_sq[k] = r_sq[k-1];
            t = (RSW'(r_sq[k-1].root) << (RB - k + 1)) | (RSW'(1) << (2 * (RB - k)));
            if (r_sq[k-1].rem >= t) begin
                n_sq[k].rem = r_sq[k-1].rem - t;
                n_sq[k].root[RB-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // differences
            r1_x1 <= in_c[0]; r1_y1 <= in_c[1];
            r1_x2 <= in_c[2]; r1_y2 <= in_c[3];
            r1_x3 <= in_c[4]; r1_y3 <= in_c[5];
            r1_d[0] <= DW'(in_c[3]) - DW'(in_c[5]);
            r1_d[1] <= DW'(in_c[5]) - DW'(in_c[1]);
            r1_d[2] <= DW'(in_c[1]) - DW'(in_c[3]);
            r1_d[3] <= DW'(in_c[4]) - DW'(in_c[2]);
            r1_d[4] <= DW'(in_c[0]) - DW'(in_c[4]);
            r1_d[5] <= DW'(in_c[2]) - DW'(in_c[0]);
            // products
            r2_m[0] <= r1_x1 * r1_d[0];
            r2_m[1] <= r1_x2 * r1_d[1];
            r2_m[2] <= r1_x3 * r1_d[2];
            r2_q[0] <= r1_x1 * r1_x1; r2_q[1] <= r1_y1 * r1_y1;
            r2_q[2] <= r1_x2 * r1_x2; r2_q[3] <= r1_y2 * r1_y2;
            r2_q[4] <= r1_x3 * r1_x3; r2_q[5] <= r1_y3 * r1_y3;
            r2_d  <= r1_d;
            r2_x1 <= r1_x1; r2_y1 <= r1_y1;
            // determinant and squared norms
            r3_det <= (DETW'(r2_m[0]) + DETW'(r2_m[1]) + DETW'(r2_m[2])) <<< 1;
            for (int i = 0; i < 3; i++) r3_s[i] <= SW'(r2_q[2*i]) + SW'(r2_q[2*i+1]);
            r3_d  <= r2_d;
            r3_x1 <= r2_x1; r3_y1 <= r2_y1;
            // split numerator products, collinearity test
            for (int i = 0; i < 6; i++) begin
                r4_lo[i] <= $signed({1'b0, r3_s[i%3][CW-1:0]}) * r3_d[i];
                r4_hi[i] <= $signed(r3_s[i%3][SW-1:CW]) * r3_d[i];
            end
            r4_found <= (r3_det != '0) && (absdet >= DETW'(r_thr));
            r4_det <= r3_det;
            r4_x1 <= r3_x1; r4_y1 <= r3_y1;
            // recombine
            for (int i = 0; i < 6; i++) r5_p[i] <= (SPW'(r4_hi[i]) <<< CW) + SPW'(r4_lo[i]);
            r5_det <= r4_det; r5_found <= r4_found;
            r5_x1 <= r4_x1; r5_y1 <= r4_y1;
            // numerators
            r6_nx <= NW'(r5_p[0]) + NW'(r5_p[1]) + NW'(r5_p[2]);
            r6_ny <= NW'(r5_p[3]) + NW'(r5_p[4]) + NW'(r5_p[5]);
            r6_det <= r5_det; r6_found <= r5_found;
            r6_x1 <= r5_x1; r6_y1 <= r5_y1;
            // magnitudes
            r7_nmx  <= r6_nx[NW-1] ? (~r6_nx + 1'b1) : r6_nx;
            r7_nmy  <= r6_ny[NW-1] ? (~r6_ny + 1'b1) : r6_ny;
            r7_dmag <= r6_det[DETW-1] ? (~r6_det + 1'b1) : r6_det;
            r7_negx <= r6_nx[NW-1] ^ r6_det[DETW-1];
            r7_negy <= r6_ny[NW-1] ^ r6_det[DETW-1];
            r7_found <= r6_found;
            r7_x1 <= r6_x1; r7_y1 <= r6_y1;
            // divider entry, quotient range check
            r_dv[0].found <= r7_found;
            r_dv[0].x1    <= r7_x1;
            r_dv[0].y1    <= r7_y1;
            r_dv[0].rem_x <= RW'(r7_nmx);
            r_dv[0].rem_y <= RW'(r7_nmy);
            r_dv[0].q_x   <= '0;
            r_dv[0].q_y   <= '0;
            r_dv[0].ovf_x <= RW'(r7_nmx) >= (RW'(r7_dmag) << QB);
            r_dv[0].ovf_y <= RW'(r7_nmy) >= (RW'(r7_dmag) << QB);
            r_dv[0].neg_x <= r7_negx;
            r_dv[0].neg_y <= r7_negy;
            r_dv[0].dmag  <= r7_dmag;
            for (int k = 1; k <= QB; k++) r_dv[k] <= n_dv[k];
            // saturate centre
            r9_cx <= n9_cx; r9_cy <= n9_cy;
            r9_clip <= n9_clx | n9_cly;
            r9_found <= r_dv[QB].found;
            r9_x1 <= r_dv[QB].x1; r9_y1 <= r_dv[QB].y1;
            // radius vector
            r10_rx <= DW'(r9_x1) - DW'($signed(r9_cx));
            r10_ry <= DW'(r9_y1) - DW'($signed(r9_cy));
            r10_cx <= r9_cx; r10_cy <= r9_cy;
            r10_clip <= r9_clip; r10_found <= r9_found;
            r11_rx2 <= r10_rx * r10_rx;
            r11_ry2 <= r10_ry * r10_ry;
            r11_cx <= r10_cx; r11_cy <= r10_cy;
            r11_clip <= r10_clip; r11_found <= r10_found;
            // root entry
            r_sq[0].found <= r11_found;
            r_sq[0].cx    <= r11_cx;
            r_sq[0].cy    <= r11_cy;
            r_sq[0].clip  <= r11_clip;
            r_sq[0].sat   <= n12_rsq[RQW-1:2*RB] != '0;
            r_sq[0].rem   <= n12_rsq[RSW-1:0];
            r_sq[0].root  <= '0;
            for (int k = 1; k <= RB; k++) r_sq[k] <= n_sq[k];
            // result
            r_o_found <= r_sq[RB].found;
            r_o_cx  <= r_sq[RB].found ? r_sq[RB].cx : '0;
            r_o_cy  <= r_sq[RB].found ? r_sq[RB].cy : '0;
            r_o_rad <= !r_sq[RB].found ? '0 :
                       (r_sq[RB].sat ? {RB{1'b1}} : r_sq[RB].root);
            r_o_clip <= r_sq[RB].found && (r_sq[RB].clip || r_sq[RB].sat);
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {{(OUT_W-3*CW+1){1'b0}}, r_o_rad, r_o_cy, r_o_cx};
    assign o_m_axis_tuser  = {r_o_clip, r_o_found};

endmodule

### hw/rtl/circ_checker.sv
module circ_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [circ_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic [circ_pkg::USR_W-1:0] o_m_axis_tuser
);
    import circ_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped under stall");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("collinear beat carries data");

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind circumcircle_of_three_points circ_checker u_circ_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
